### hdl/mcar_pkg.sv
// Shared types and constants for the mode command acknowledge retry controller.
package mcar_pkg;

  typedef enum logic [1:0] {
    OP_PRESS  = 2'd0,
    OP_FRAME  = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MSG_ACK   = 3'd0,
    MSG_CMD   = 3'd1,
    MSG_DAT   = 3'd2,
    MSG_EVT   = 3'd3,
    MSG_STS   = 3'd4,
    MSG_ERR   = 3'd5,
    MSG_RSVD6 = 3'd6,
    MSG_RSVD7 = 3'd7
  } msg_t;

  typedef enum logic [2:0] {
    FT_EVT  = 3'd0,
    FT_STS  = 3'd1,
    FT_DAT  = 3'd2,
    FT_ACK  = 3'd3,
    FT_ERR  = 3'd4,
    FT_NONE = 3'd5
  } frame_t;

  typedef enum logic [1:0] {
    MODE_PATROL = 2'd0,
    MODE_STOP   = 2'd1,
    MODE_DEPLOY = 2'd2,
    MODE_RETURN = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic CFG_MAX_RETRIES  = 1'b0;
  localparam logic CFG_RETRY_PERIOD = 1'b1;

  localparam logic [7:0]  MAX_RETRIES_RST  = 8'd3;
  localparam logic [15:0] RETRY_PERIOD_RST = 16'd500;

  localparam int NUM_FRAMES = 3;
  localparam int CNT_OUT_W  = 16;

  typedef struct packed {
    logic                 press_accepted;
    mode_t                current_mode;
    logic                 waiting_ack;
    logic [CNT_OUT_W-1:0] ignored_presses;
    logic [CNT_OUT_W-1:0] accepted_changes;
    logic [CNT_OUT_W-1:0] abandoned_waits;
  } status_t;

  typedef struct packed {
    frame_t     ftype;
    mode_t      fmode;
    logic [7:0] fparam;
  } frame_rec_t;

  // Up to three frames from one item, plus status after the step
  typedef struct packed {
    logic [1:0]                       last_idx;
    frame_rec_t [NUM_FRAMES-1:0]      frames;
    status_t                          status;
  } bundle_t;

endpackage

### hdl/mcar_core.sv
// Input register, controller state and single-pass step logic.
module mcar_core #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_param,
  input  logic [2:0]        in_msg_type,
  input  logic              in_msg_ok,
  input  logic [31:0]       in_now,
  output logic              b_valid,
  input  logic              b_ready,
  output mcar_pkg::bundle_t b_data
);

  logic [7:0]  max_retries;
  logic [15:0] retry_period;

  logic        r_valid;
  logic [1:0]  r_op;
  logic [7:0]  r_param;
  logic [2:0]  r_msg_type;
  logic        r_msg_ok;
  logic [31:0] r_now;

  mcar_pkg::mode_t mode_reg, mode_reg_next;
  logic            pending, pending_next;
  mcar_pkg::mode_t pending_mode, pending_mode_next;
  logic [7:0]      retries, retries_next;
  logic [31:0]     deadline, deadline_next;
  logic [CW-1:0]   ignored_cnt, ignored_cnt_next;
  logic [CW-1:0]   change_cnt, change_cnt_next;
  logic [CW-1:0]   timeout_cnt, timeout_cnt_next;

  logic move;

  assign move     = r_valid && b_ready;
  assign in_ready = !r_valid || b_ready;
  assign b_valid  = r_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries  <= mcar_pkg::MAX_RETRIES_RST;
      retry_period <= mcar_pkg::RETRY_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == mcar_pkg::CFG_MAX_RETRIES) begin
        max_retries <= cfg_data[7:0];
      end else begin
        retry_period <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_ready) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_op       <= in_op;
      r_param    <= in_param;
      r_msg_type <= in_msg_type;
      r_msg_ok   <= in_msg_ok;
      r_now      <= in_now;
    end
  end

  always_comb begin
    logic [31:0] since;
    mcar_pkg::mode_t nm;
    since             = r_now - deadline;
    nm                = mcar_pkg::mode_t'(mode_reg + 2'd1);
    mode_reg_next     = mode_reg;
    pending_next      = pending;
    pending_mode_next = pending_mode;
    retries_next      = retries;
    deadline_next     = deadline;
    ignored_cnt_next  = ignored_cnt;
    change_cnt_next   = change_cnt;
    timeout_cnt_next  = timeout_cnt;
    b_data            = '0;
    b_data.last_idx   = 2'd0;
    for (int i = 0; i < mcar_pkg::NUM_FRAMES; i++) begin
      b_data.frames[i].ftype = mcar_pkg::FT_NONE;
    end

    case (mcar_pkg::op_t'(r_op))
      mcar_pkg::OP_PRESS: begin
        if (pending) begin
          ignored_cnt_next = ignored_cnt + 1'b1;
        end else begin
          mode_reg_next            = nm;
          change_cnt_next          = change_cnt + 1'b1;
          b_data.last_idx          = 2'd2;
          b_data.frames[0].ftype   = mcar_pkg::FT_EVT;
          b_data.frames[0].fmode   = nm;
          b_data.frames[1].ftype   = mcar_pkg::FT_STS;
          // return shows up as stop in the status frame
          b_data.frames[1].fmode   = (nm == mcar_pkg::MODE_RETURN) ? mcar_pkg::MODE_STOP : nm;
          b_data.frames[2].ftype   = mcar_pkg::FT_DAT;
          b_data.frames[2].fparam  = r_param;
          pending_mode_next        = nm;
          pending_next             = 1'b1;
          retries_next             = max_retries;
          deadline_next            = r_now + {16'd0, retry_period};
          b_data.status.press_accepted = 1'b1;
        end
      end
      mcar_pkg::OP_FRAME: begin
        if (r_msg_type == mcar_pkg::MSG_ACK) begin
          if (r_msg_ok) begin
            pending_next = 1'b0;
          end
        end else if (r_msg_type inside {[mcar_pkg::MSG_CMD:mcar_pkg::MSG_STS]}) begin
          b_data.frames[0].ftype = mcar_pkg::FT_ACK;
        end
      end
      mcar_pkg::OP_TICK: begin
        // deadline reached when the wrapped difference is non-negative
        if (pending && !since[31]) begin
          if (retries != 8'd0) begin
            b_data.frames[0].ftype = mcar_pkg::FT_EVT;
            b_data.frames[0].fmode = pending_mode;
            retries_next           = retries - 8'd1;
            deadline_next          = r_now + {16'd0, retry_period};
          end else begin
            b_data.frames[0].ftype = mcar_pkg::FT_ERR;
            pending_next           = 1'b0;
            timeout_cnt_next       = timeout_cnt + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    b_data.status.current_mode     = mode_reg_next;
    b_data.status.waiting_ack      = pending_next;
    b_data.status.ignored_presses  = mcar_pkg::CNT_OUT_W'(ignored_cnt_next);
    b_data.status.accepted_changes = mcar_pkg::CNT_OUT_W'(change_cnt_next);
    b_data.status.abandoned_waits  = mcar_pkg::CNT_OUT_W'(timeout_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= mcar_pkg::MODE_STOP;
      pending      <= 1'b0;
      pending_mode <= mcar_pkg::MODE_PATROL;
      retries      <= 8'd0;
      deadline     <= 32'd0;
      ignored_cnt  <= '0;
      change_cnt   <= '0;
      timeout_cnt  <= '0;
    end else if (move) begin
      mode_reg     <= mode_reg_next;
      pending      <= pending_next;
      pending_mode <= pending_mode_next;
      retries      <= retries_next;
      deadline     <= deadline_next;
      ignored_cnt  <= ignored_cnt_next;
      change_cnt   <= change_cnt_next;
      timeout_cnt  <= timeout_cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_press_arms_wait: assert property (@(posedge clk) disable iff (rst)
    move && b_data.status.press_accepted |=> pending && (retries == $past(max_retries)))
    else $error("accepted press did not arm the acknowledge wait");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(mode_reg) && $stable(pending) && $stable(change_cnt))
    else $error("state changed without an item");

  a_ignore_when_pending: assert property (@(posedge clk) disable iff (rst)
    move && pending && (r_op == mcar_pkg::OP_PRESS) |-> !b_data.status.press_accepted)
    else $error("press accepted while acknowledge pending");
`endif

endmodule

### hdl/mcar_out.sv
// Result buffer that plays out the frames of one item in order.
module mcar_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              b_valid,
  output logic              b_ready,
  input  mcar_pkg::bundle_t b_data,
  output logic              o_valid,
  input  logic              o_ready,
  output logic              o_last,
  output mcar_pkg::frame_rec_t o_frame,
  output mcar_pkg::status_t o_status
);

  logic              valid;
  logic [1:0]        idx;
  mcar_pkg::bundle_t buf_q;
  logic              take;

  assign take     = valid && o_ready;
  assign o_last   = (idx == buf_q.last_idx);
  // next bundle loads as the final frame of the current one leaves
  assign b_ready  = !valid || (take && o_last);
  assign o_valid  = valid;
  assign o_frame  = buf_q.frames[idx];
  assign o_status = buf_q.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (b_ready) begin
      valid <= b_valid;
      idx   <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && b_valid) begin
      buf_q <= b_data;
    end
  end

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= buf_q.last_idx)
    else $error("frame index past last frame");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    take && !o_last |=> valid && (idx == $past(idx) + 2'd1))
    else $error("frame index did not advance");

  a_press_three: assert property (@(posedge clk) disable iff (rst)
    valid && buf_q.status.press_accepted |-> buf_q.last_idx == 2'd2)
    else $error("accepted press without three frames");
`endif

endmodule

### hdl/mode_command_ack_retry_controller.sv
// Top level of the stop-and-wait mode command controller with acknowledge retry.
//
// Input stream s_*: one item per handshake; s_tuser carries the operation
// (press, received frame, tick), s_tdata the parameter byte, message type,
// ok flag and millisecond time. Output stream m_*: one to three frames per
// item, m_tlast on the final frame of each item, m_tuser the frame type.
// Config port: cfg_we writes cfg_data into register cfg_index (0 max
// retries, 1 retry period in ms) at the clock edge; write only when idle.
//
// Path: an item taken on s_* sits in the input register; once the result
// register is free it loads the item's first frame, which is then on m_*.
// The frame count at the output sets the pace: a press that starts a
// transaction plays out three frames, any other item one frame, with the
// next item taken while frames play out.
// When m_tready is low the result register holds, the input register fills
// and s_tready drops; nothing is lost.
// Reset (synchronous, rst high): mode stop, no pending acknowledge,
// counters zero, max retries 3, retry period 500 ms.
module mode_command_ack_retry_controller #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd_param[7:0], msg_type[10:8], msg_is_ok[11], now_ms[43:12]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // frame_mode[1:0], frame_param[9:2], press_accepted[10],
                                 // current_mode[12:11], waiting_ack[13], ignored_presses[29:14],
                                 // accepted_changes[45:30], abandoned_waits[61:46]
  output logic [2:0]  m_tuser,   // frame_type[2:0]
  output logic        m_tlast
);

  logic                 b_valid;
  logic                 b_ready;
  mcar_pkg::bundle_t    b_data;
  mcar_pkg::frame_rec_t o_frame;
  mcar_pkg::status_t    o_status;

  mcar_core #(
    .CW (COUNTER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_param    (s_tdata[7:0]),
    .in_msg_type (s_tdata[10:8]),
    .in_msg_ok   (s_tdata[11]),
    .in_now      (s_tdata[43:12]),
    .b_valid     (b_valid),
    .b_ready     (b_ready),
    .b_data      (b_data)
  );

  mcar_out u_out (
    .clk      (clk),
    .rst      (rst),
    .b_valid  (b_valid),
    .b_ready  (b_ready),
    .b_data   (b_data),
    .o_valid  (m_tvalid),
    .o_ready  (m_tready),
    .o_last   (m_tlast),
    .o_frame  (o_frame),
    .o_status (o_status)
  );

  assign m_tuser = o_frame.ftype;
  assign m_tdata = {2'b00,
                    o_status.abandoned_waits,
                    o_status.accepted_changes,
                    o_status.ignored_presses,
                    o_status.waiting_ack,
                    o_status.current_mode,
                    o_status.press_accepted,
                    o_frame.fparam,
                    o_frame.fmode};

endmodule

### dv/mode_command_ack_retry_controller_tb.sv
// Self-checking testbench for the mode command acknowledge retry controller.
`timescale 1ns / 100ps

module mode_command_ack_retry_controller_tb;

  typedef struct {
    mcar_pkg::frame_t  ftype;
    mcar_pkg::mode_t   fmode;
    logic [7:0]        fparam;
    logic              last;
    mcar_pkg::status_t st;
  } frame_exp_t;

  // Tracks mode, acknowledge wait and counters; holds the frames still owed.
  class frame_scoreboard;
    logic [7:0]      max_retries;
    logic [15:0]     retry_period;
    mcar_pkg::mode_t mode;
    logic            awaiting;
    mcar_pkg::mode_t sent_mode;
    logic [7:0]      resend_budget;
    logic [31:0]     deadline;
    logic [15:0]     ignored_cnt;
    logic [15:0]     change_cnt;
    logic [15:0]     timeout_cnt;
    frame_exp_t      frames_q[$];
    int              errors;

    function new();
      max_retries   = mcar_pkg::MAX_RETRIES_RST;
      retry_period  = mcar_pkg::RETRY_PERIOD_RST;
      mode          = mcar_pkg::MODE_STOP;
      awaiting      = 1'b0;
      sent_mode     = mcar_pkg::MODE_PATROL;
      resend_budget = '0;
      deadline      = '0;
      ignored_cnt   = '0;
      change_cnt    = '0;
      timeout_cnt   = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == mcar_pkg::CFG_MAX_RETRIES) max_retries = val[7:0];
      else retry_period = val;
    endfunction

    function frame_exp_t mk(mcar_pkg::frame_t ft, mcar_pkg::mode_t fm, logic [7:0] fp);
      frame_exp_t r;
      r.ftype  = ft;
      r.fmode  = fm;
      r.fparam = fp;
      r.last   = 1'b0;
      r.st     = '0;
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] param, logic [2:0] mtype,
                             logic ok, logic [31:0] now);
      frame_exp_t batch[$];
      frame_exp_t r;
      logic       accepted;
      logic [1:0] nxt;
      logic [31:0] since;
      accepted = 1'b0;
      case (op)
        mcar_pkg::OP_PRESS: begin
          if (awaiting) begin
            ignored_cnt = ignored_cnt + 16'd1;
          end else begin
            nxt        = mode + 2'd1;
            mode       = mcar_pkg::mode_t'(nxt);
            change_cnt = change_cnt + 16'd1;
            batch.push_back(mk(mcar_pkg::FT_EVT, mode, 8'd0));
            // return is reported as stop in the status frame
            batch.push_back(mk(mcar_pkg::FT_STS,
                               (mode == mcar_pkg::MODE_RETURN) ? mcar_pkg::MODE_STOP : mode,
                               8'd0));
            batch.push_back(mk(mcar_pkg::FT_DAT, mcar_pkg::MODE_PATROL, param));
            sent_mode     = mode;
            awaiting      = 1'b1;
            resend_budget = max_retries;
            deadline      = now + {16'd0, retry_period};
            accepted      = 1'b1;
          end
        end
        mcar_pkg::OP_FRAME: begin
          if (mtype == mcar_pkg::MSG_ACK) begin
            if (awaiting && ok) awaiting = 1'b0;
          end else if (mtype inside {[mcar_pkg::MSG_CMD:mcar_pkg::MSG_STS]}) begin
            batch.push_back(mk(mcar_pkg::FT_ACK, mcar_pkg::MODE_PATROL, 8'd0));
          end
        end
        mcar_pkg::OP_TICK: begin
          since = now - deadline;
          if (awaiting && !since[31]) begin
            if (resend_budget != 8'd0) begin
              batch.push_back(mk(mcar_pkg::FT_EVT, sent_mode, 8'd0));
              resend_budget = resend_budget - 8'd1;
              deadline      = now + {16'd0, retry_period};
            end else begin
              batch.push_back(mk(mcar_pkg::FT_ERR, mcar_pkg::MODE_PATROL, 8'd0));
              awaiting    = 1'b0;
              timeout_cnt = timeout_cnt + 16'd1;
            end
          end
        end
        default: ;
      endcase
      if (batch.size() == 0) batch.push_back(mk(mcar_pkg::FT_NONE, mcar_pkg::MODE_PATROL, 8'd0));
      foreach (batch[i]) begin
        r = batch[i];
        r.last                = (i == batch.size() - 1);
        r.st.press_accepted   = accepted;
        r.st.current_mode     = mode;
        r.st.waiting_ack      = awaiting;
        r.st.ignored_presses  = ignored_cnt;
        r.st.accepted_changes = change_cnt;
        r.st.abandoned_waits  = timeout_cnt;
        frames_q.push_back(r);
      end
    endfunction

    function void compare(string fld, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] ft, logic [63:0] d, logic lst);
      frame_exp_t e;
      if (frames_q.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual type %0d data %h",
                 $time, ft, d);
        errors++;
        return;
      end
      e = frames_q.pop_front();
      compare("frame_type", e.ftype, ft);
      compare("frame_mode", e.fmode, d[1:0]);
      compare("frame_param", e.fparam, d[9:2]);
      compare("last", e.last, lst);
      compare("press_accepted", e.st.press_accepted, d[10]);
      compare("current_mode", e.st.current_mode, d[12:11]);
      compare("waiting_ack", e.st.waiting_ack, d[13]);
      compare("ignored_presses", e.st.ignored_presses, d[29:14]);
      compare("accepted_changes", e.st.accepted_changes, d[45:30]);
      compare("abandoned_waits", e.st.abandoned_waits, d[61:46]);
    endfunction

    function int owed();
      return frames_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  frame_scoreboard sb;
  bit          hold_req;
  int          burst_left;
  logic [31:0] t_ms;

  mode_command_ack_retry_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("mode_command_ack_retry_controller_tb: done, errors");
    $finish;
  end

  // Output side: a randomly drawn stall pattern, redrawn when its stretch runs out; long hold on request.
  initial begin
    int stall_kind;
    int stretch_left;
    int cyc;
    stall_kind   = 0;
    stretch_left = 0;
    cyc          = 0;
    m_tready     = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stall_kind   = $urandom_range(0, 3);
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        case (stall_kind)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= (cyc % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  task automatic send_item(logic [1:0] op, logic [7:0] param, logic [2:0] mtype,
                           logic ok, logic [31:0] now);
    int gap_len;
    if (burst_left == 0) begin
      gap_len    = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, now, ok, mtype, param};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(op, param, mtype, ok, now);
    burst_left--;
  endtask

  task automatic press(logic [7:0] param);
    send_item(mcar_pkg::OP_PRESS, param, 3'($urandom), 1'($urandom), t_ms);
  endtask

  task automatic rx_frame(logic [2:0] mtype, logic ok);
    send_item(mcar_pkg::OP_FRAME, 8'($urandom), mtype, ok, $urandom);
  endtask

  task automatic tick(logic [31:0] now);
    send_item(mcar_pkg::OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom), now);
  endtask

  // Let every owed frame arrive and leave the input idle before touching registers.
  task automatic drain();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.owed() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] retries, logic [15:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= mcar_pkg::CFG_MAX_RETRIES;
    cfg_data  <= {8'd0, retries};
    @(posedge clk);
    sb.write_reg(mcar_pkg::CFG_MAX_RETRIES, {8'd0, retries});
    cfg_index <= mcar_pkg::CFG_RETRY_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    sb.write_reg(mcar_pkg::CFG_RETRY_PERIOD, period);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly press/tick/ack sequences on a running clock, some noise mixed in.
  task automatic random_traffic(int n, int period);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        press(8'($urandom));
      end else if (sel < 68) begin
        t_ms = t_ms + $urandom_range(0, 2 * period + 2);
        tick(t_ms);
      end else if (sel < 80) begin
        rx_frame(mcar_pkg::MSG_ACK, 1'b1);
      end else if (sel < 92) begin
        rx_frame(3'($urandom), 1'($urandom));
      end else if (sel < 96) begin
        tick($urandom);
      end else begin
        send_item(mcar_pkg::OP_UNUSED, 8'($urandom), 3'($urandom), 1'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    sb         = new();
    hold_req   = 1'b0;
    burst_left = 0;
    t_ms       = 32'd1000;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = mcar_pkg::CFG_MAX_RETRIES;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = mcar_pkg::OP_PRESS;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, idle cases, every frame type, retries, mode wrap
    tick(t_ms);
    rx_frame(mcar_pkg::MSG_ACK, 1'b1);
    press(8'd0);
    press(8'd255);
    tick(t_ms + 32'd499);
    rx_frame(mcar_pkg::MSG_ACK, 1'b0);
    rx_frame(mcar_pkg::MSG_CMD, 1'b0);
    rx_frame(mcar_pkg::MSG_DAT, 1'b1);
    rx_frame(mcar_pkg::MSG_EVT, 1'b0);
    rx_frame(mcar_pkg::MSG_STS, 1'b1);
    rx_frame(mcar_pkg::MSG_ERR, 1'b1);
    rx_frame(mcar_pkg::MSG_RSVD6, 1'b0);
    rx_frame(mcar_pkg::MSG_RSVD7, 1'b1);
    send_item(mcar_pkg::OP_UNUSED, 8'hff, mcar_pkg::MSG_RSVD7, 1'b1, 32'hffff_ffff);
    for (int k = 0; k < 4; k++) begin
      t_ms = t_ms + 32'd500;
      tick(t_ms);
    end
    press(8'h5a);
    rx_frame(mcar_pkg::MSG_ACK, 1'b1);
    press(8'ha5);
    rx_frame(mcar_pkg::MSG_ACK, 1'b1);
    press(8'h81);
    rx_frame(mcar_pkg::MSG_ACK, 1'b1);
    random_traffic(40, 500);
    drain();

    // No retries and zero period: the very next tick times out
    set_regs(8'd0, 16'd0);
    t_ms = $urandom;
    press(8'h11);
    tick(t_ms);
    random_traffic(50, 0);
    drain();

    // Largest settings, clock just below the 32-bit wrap
    set_regs(8'd255, 16'd65535);
    t_ms = 32'hffff_0000;
    press(8'h22);
    tick(32'hffff_8000);
    tick(32'h0000_ffff);
    random_traffic(50, 65535);
    drain();

    // Output held off long enough to back up the input
    set_regs(8'd2, 16'd7);
    hold_req = 1'b1;
    random_traffic(60, 7);
    drain();

    set_regs(8'd1, 16'd1);
    random_traffic(50, 1);
    drain();

    set_regs(8'd5, 16'd300);
    t_ms = $urandom;
    random_traffic(50, 300);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("mode_command_ack_retry_controller_tb: done, clean");
    end else begin
      $display("mode_command_ack_retry_controller_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mcar_pkg.sv
hdl/mcar_core.sv
hdl/mcar_out.sv
hdl/mode_command_ack_retry_controller.sv
dv/mode_command_ack_retry_controller_tb.sv
